[src/crtc_pkg.sv]
package crtc_pkg;

  localparam int IDX_W = 7;

  // Access kind and port codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // Clock and status indices
  localparam logic [IDX_W-1:0] IDX_SECONDS  = 7'h00;
  localparam logic [IDX_W-1:0] IDX_MINUTES  = 7'h02;
  localparam logic [IDX_W-1:0] IDX_HOURS    = 7'h04;
  localparam logic [IDX_W-1:0] IDX_WEEKDAY  = 7'h06;
  localparam logic [IDX_W-1:0] IDX_MONTHDAY = 7'h07;
  localparam logic [IDX_W-1:0] IDX_MONTH    = 7'h08;
  localparam logic [IDX_W-1:0] IDX_YEAR     = 7'h09;
  localparam logic [IDX_W-1:0] IDX_STATUS_C = 7'h0C;
  localparam logic [IDX_W-1:0] IDX_STATUS_D = 7'h0D;
  localparam logic [IDX_W-1:0] IDX_CENTURY  = 7'h32;

  typedef struct packed {
    logic [7:0] hi;   // year / 100
    logic [6:0] lo;   // year % 100
  } year_split_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  monthday;
    logic [3:0]  month;
    year_split_t year;
  } crtc_time_t;

  // Divide by 100 as a multiply by 5243 / 2^19; exact over the full 14-bit range
  function automatic year_split_t year_split(input logic [13:0] year);
    logic [26:0] prod;
    logic [7:0]  quo;
    logic [13:0] back;
    prod = 27'(year) * 27'd5243;
    quo  = prod[26:19];
    back = 14'(quo) * 14'd100;
    return '{hi: quo, lo: 7'(year - back)};
  endfunction

  // Binary to packed BCD, tens digit kept to four bits; divide by 10 as 205 / 2^11
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  back;
    logic [7:0]  rem;
    prod = 16'(v) * 16'd205;
    tens = prod[15:11];
    back = 8'(tens) * 8'd10;
    rem  = v - back;
    return {tens[3:0], rem[3:0]};
  endfunction

endpackage

[src/crtc_ram.sv]
module crtc_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output logic              rd_hit
);

  logic [7:0]     mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Per-byte written flags; rd_hit lets the reader show unwritten bytes as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_addr];
      end
    end
  end

endmodule

[src/crtc_rsp_sel.sv]
module crtc_rsp_sel (
  input  logic [crtc_pkg::IDX_W-1:0] idx,
  input  logic                       in_range,
  input  crtc_pkg::crtc_time_t       now,
  input  logic [7:0]                 ram_data,
  input  logic                       ram_hit,
  output logic [7:0]                 rsp_byte
);
  import crtc_pkg::*;

  logic [7:0] clk_val;
  logic       is_clock;

  always_comb begin
    is_clock = 1'b1;
    case (idx)
      IDX_SECONDS:  clk_val = 8'(now.second);
      IDX_MINUTES:  clk_val = 8'(now.minute);
      IDX_HOURS:    clk_val = 8'(now.hour);
      IDX_WEEKDAY:  clk_val = 8'(now.weekday) + 8'd1;
      IDX_MONTHDAY: clk_val = 8'(now.monthday);
      IDX_MONTH:    clk_val = 8'(now.month) + 8'd1;
      IDX_YEAR:     clk_val = 8'(now.year.lo);
      IDX_CENTURY:  clk_val = now.year.hi;
      default: begin
        clk_val  = '0;
        is_clock = 1'b0;
      end
    endcase
  end

  assign rsp_byte = is_clock ? to_bcd(clk_val)
                  : ((in_range && ram_hit) ? ram_data : 8'h00);

endmodule

[src/cmos_rtc_register_port_core.sv]
// A data port read passes from the request stage into the response register (read_data).
// Throughput: one request per cycle while responses drain; req_ready stays high
//   whenever the response register is empty or being drained.
// Reset (rst, synchronous): index clears to zero and every RAM byte reads as zero,
//   through per-byte written flags; no clearing sweep, requests accepted at once.
module cmos_rtc_register_port_core #(
  parameter int RAM_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        func,
  input  logic        port_select,
  input  logic [7:0]  write_data,
  input  logic [5:0]  now_second,
  input  logic [5:0]  now_minute,
  input  logic [4:0]  now_hour,
  input  logic [2:0]  now_weekday,
  input  logic [4:0]  now_monthday,
  input  logic [3:0]  now_month,
  input  logic [13:0] now_year,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [7:0]  read_data
);
  import crtc_pkg::*;

  localparam int ADDR_W = $clog2(RAM_DEPTH);
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W+1)'(RAM_DEPTH);

  // Current index register (NMI mask bit is dropped on write)
  logic [IDX_W-1:0] idx;

  // Request stage: a data port read waiting for its RAM byte
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_in_range;
  crtc_time_t       s1_time;

  logic             accept;
  logic             in_range;
  logic             rd_req;
  logic             wr_en;
  logic             s1_adv;
  logic [7:0]       ram_data;
  logic             ram_hit;
  logic [7:0]       rsp_byte;

  assign accept   = req_valid && req_ready;
  assign in_range = {1'b0, idx} < DEPTH_LIM;

  // Status registers C and D are read-only; bytes beyond the RAM are dropped
  assign wr_en = accept && (func == FUNC_WRITE) && (port_select == PORT_DATA)
              && (idx != IDX_STATUS_C) && (idx != IDX_STATUS_D) && in_range;

  // Only data port reads produce a response
  assign rd_req = accept && (func == FUNC_READ) && (port_select == PORT_DATA);

  // Response register parts the two sides; the request stage drains into it
  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (accept && (func == FUNC_WRITE) && (port_select == PORT_INDEX)) begin
      idx <= write_data[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_req) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Year split into century and year-of-century on the way in
  always_ff @(posedge clk) begin
    if (rd_req) begin
      s1_idx           <= idx;
      s1_in_range      <= in_range;
      s1_time.second   <= now_second;
      s1_time.minute   <= now_minute;
      s1_time.hour     <= now_hour;
      s1_time.weekday  <= now_weekday;
      s1_time.monthday <= now_monthday;
      s1_time.month    <= now_month;
      s1_time.year     <= year_split(now_year);
    end
  end

  // A write at one edge is visible to a read accepted at the next
  crtc_ram #(
    .DEPTH  (RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (idx[ADDR_W-1:0]),
    .wr_data (write_data),
    .rd_en   (rd_req && in_range),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (ram_data),
    .rd_hit  (ram_hit)
  );

  crtc_rsp_sel u_sel (
    .idx      (s1_idx),
    .in_range (s1_in_range),
    .now      (s1_time),
    .ram_data (ram_data),
    .ram_hit  (ram_hit),
    .rsp_byte (rsp_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data <= rsp_byte;
    end
  end

endmodule

[src/crtc_checker.sv]
module crtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        func,
  input logic        port_select,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  read_data
);
  import crtc_pkg::*;

  logic rd_acc;
  assign rd_acc = req_valid && req_ready && (func == FUNC_READ) && (port_select == PORT_DATA);

  // Nothing in the response register straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

  // A stalled response holds its byte
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data))
    else $error("stalled response changed");

  // Requests are never refused while the response side can drain
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("request refused with free response slot");

  // Draining with no data read empties the request stage, then the response register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!rd_acc && rsp_ready) ##1 (!rd_acc && rsp_ready) |=> !rsp_valid)
    else $error("response without a data port read");

endmodule

bind cmos_rtc_register_port_core crtc_checker u_crtc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_ready   (req_ready),
  .func        (func),
  .port_select (port_select),
  .rsp_valid   (rsp_valid),
  .rsp_ready   (rsp_ready),
  .read_data   (read_data)
);

[sim/cmos_rtc_register_port_core_tb.sv]
`timescale 1ns / 100ps

module cmos_rtc_register_port_core_tb;
  import crtc_pkg::*;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  monthday;
    logic [3:0]  month;
    logic [13:0] year;
  } wall_time_t;

  // Tracks the index and RAM, queues the byte each data read should return
  class rtc_port_scoreboard #(int RAM_DEPTH = 128);
    logic [IDX_W-1:0] cur_index;
    logic [7:0]       ram_bytes [RAM_DEPTH];
    logic [7:0]       read_bytes_due [$];
    int               mismatches;

    function new();
      cur_index  = '0;
      mismatches = 0;
      foreach (ram_bytes[i]) ram_bytes[i] = 8'h00;
    endfunction

    function logic [7:0] bcd_byte(int unsigned v);
      return 8'(((v / 10) << 4) + (v % 10));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function int outstanding();
      return read_bytes_due.size();
    endfunction

    function void note_request(logic f, logic p, logic [7:0] wd, wall_time_t t);
      logic [7:0] rd;
      if (f == FUNC_WRITE) begin
        if (p == PORT_INDEX) begin
          cur_index = wd[IDX_W-1:0];   // NMI mask bit dropped
        end else if (cur_index != IDX_STATUS_C && cur_index != IDX_STATUS_D &&
                     int'(cur_index) < RAM_DEPTH) begin
          ram_bytes[cur_index] = wd;
        end
      end else if (p == PORT_DATA) begin
        case (cur_index)
          IDX_SECONDS:  rd = bcd_byte(t.second);
          IDX_MINUTES:  rd = bcd_byte(t.minute);
          IDX_HOURS:    rd = bcd_byte(t.hour);
          IDX_WEEKDAY:  rd = bcd_byte(t.weekday + 1);
          IDX_MONTHDAY: rd = bcd_byte(t.monthday);
          IDX_MONTH:    rd = bcd_byte(t.month + 1);
          IDX_YEAR:     rd = bcd_byte(t.year % 100);
          IDX_CENTURY:  rd = bcd_byte(t.year / 100);
          default:      rd = (int'(cur_index) < RAM_DEPTH) ? ram_bytes[cur_index] : 8'h00;
        endcase
        read_bytes_due.push_back(rd);
      end
    endfunction

    function void check_response(logic [7:0] got);
      logic [7:0] want;
      if (read_bytes_due.size() == 0) begin
        report($sformatf("unexpected read_data %02h", got));
        return;
      end
      want = read_bytes_due.pop_front();
      if (got !== want)
        report($sformatf("read_data mismatch: expected %02h, got %02h", want, got));
    endfunction
  endclass

  localparam int RAM_DEPTH   = 128;
  localparam int HOLD_CYCLES = 400;       // long response back-pressure stretch
  localparam int CYCLE_LIMIT = 200_000;   // far beyond the slowest legal run
  localparam int PHASE_ITEMS = 475;       // four phases, roughly 1900 requests

  localparam logic [IDX_W-1:0] CLOCK_INDICES [8] = '{
    IDX_SECONDS, IDX_MINUTES, IDX_HOURS, IDX_WEEKDAY,
    IDX_MONTHDAY, IDX_MONTH, IDX_YEAR, IDX_CENTURY
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic        func;
  logic        port_select;
  logic [7:0]  write_data;
  logic [5:0]  now_second;
  logic [5:0]  now_minute;
  logic [4:0]  now_hour;
  logic [2:0]  now_weekday;
  logic [4:0]  now_monthday;
  logic [3:0]  now_month;
  logic [13:0] now_year;
  logic        rsp_valid;
  logic        rsp_ready;
  logic [7:0]  read_data;

  rtc_port_scoreboard #(RAM_DEPTH) sb;

  wall_time_t now_t;             // time fields for the next request
  int         items_sent = 0;
  int         send_idle_pct = 0; // chance per cycle that the sender holds back
  int         rsp_stall_pct = 0; // chance per cycle that the receiver stalls
  int         hold_requests = 0; // bumped by the stimulus to start a long hold
  int         hold_taken = 0;
  int         hold_left = 0;
  int         cycle_count = 0;

  cmos_rtc_register_port_core #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .func         (func),
    .port_select  (port_select),
    .write_data   (write_data),
    .now_second   (now_second),
    .now_minute   (now_minute),
    .now_hour     (now_hour),
    .now_weekday  (now_weekday),
    .now_monthday (now_monthday),
    .now_month    (now_month),
    .now_year     (now_year),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .read_data    (read_data)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cmos_rtc_register_port_core test failed");
      $finish;
    end
  end

  // Every accepted request goes to the predictor, sampled at the edge itself
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready)
      sb.note_request(func, port_select, write_data,
                      wall_time_t'{now_second, now_minute, now_hour, now_weekday,
                                   now_monthday, now_month, now_year});
  end

  // Response side: check each accepted byte, then pick next cycle's ready.
  // A long hold is counted here once the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_response(read_data);
    if (hold_requests != hold_taken) begin
      hold_taken = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Called just after an edge; returns at the edge that takes the request.
  // Valid is only dropped when an idle gap is chosen, never toggled in one step.
  task automatic send_request(input logic f, input logic p, input logic [7:0] wd);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid    <= 1'b1;
    func         <= f;
    port_select  <= p;
    write_data   <= wd;
    now_second   <= now_t.second;
    now_minute   <= now_t.minute;
    now_hour     <= now_t.hour;
    now_weekday  <= now_t.weekday;
    now_monthday <= now_t.monthday;
    now_month    <= now_t.month;
    now_year     <= now_t.year;
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  // Mostly calendar-legal time; now and then any bit pattern the ports allow
  task automatic pick_time();
    logic [$bits(wall_time_t)-1:0] raw;
    if ($urandom_range(99) < 80) begin
      now_t.second   = 6'($urandom_range(60));
      now_t.minute   = 6'($urandom_range(59));
      now_t.hour     = 5'($urandom_range(23));
      now_t.weekday  = 3'($urandom_range(6));
      now_t.monthday = 5'($urandom_range(31, 1));
      now_t.month    = 4'($urandom_range(11));
      now_t.year     = 14'($urandom_range(9999));
    end else begin
      raw   = $bits(wall_time_t)'({$urandom, $urandom});
      now_t = raw;
    end
  endtask

  // One index selection followed by a few data accesses, or a lone noise request
  task automatic random_burst();
    logic [IDX_W-1:0] idx;
    int               n;
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: idx = CLOCK_INDICES[$urandom_range(7)];
        5:             idx = $urandom_range(1) ? IDX_STATUS_C : IDX_STATUS_D;
        6, 7:          idx = IDX_W'($urandom);
        default:       idx = IDX_W'($urandom_range(8'h13, 8'h0A)); // small pool, reuse
      endcase
      pick_time();
      send_request(FUNC_WRITE, PORT_INDEX, {1'($urandom), idx});
      n = $urandom_range(4, 1);
      repeat (n) begin
        pick_time();
        send_request(($urandom_range(99) < 40) ? FUNC_WRITE : FUNC_READ, PORT_DATA,
                     8'($urandom));
      end
    end else begin
      pick_time();
      send_request(1'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int target;
    sb           = new();
    rst          = 1'b1;
    req_valid    = 1'b0;
    func         = FUNC_READ;
    port_select  = PORT_INDEX;
    write_data   = 8'h00;
    now_second   = '0;
    now_minute   = '0;
    now_hour     = '0;
    now_weekday  = '0;
    now_monthday = '0;
    now_month    = '0;
    now_year     = '0;
    rsp_ready    = 1'b0;
    now_t        = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: index is zero out of reset, so the first data read gives seconds
    now_t.second = 6'd59;
    send_request(FUNC_READ, PORT_DATA, 8'h00);
    // every clock index with every time field at its all-ones extreme
    now_t = '1;
    foreach (CLOCK_INDICES[i]) begin
      send_request(FUNC_WRITE, PORT_INDEX, {1'b0, CLOCK_INDICES[i]});
      send_request(FUNC_READ, PORT_DATA, 8'h00);
    end
    now_t = '0;
    send_request(FUNC_READ, PORT_DATA, 8'hFF);            // century of year zero
    // status registers are read-only; NMI mask bit set on the index write
    send_request(FUNC_WRITE, PORT_INDEX, {1'b1, IDX_STATUS_C});
    send_request(FUNC_WRITE, PORT_DATA, 8'hFF);
    send_request(FUNC_READ, PORT_DATA, 8'h00);
    send_request(FUNC_WRITE, PORT_INDEX, {1'b0, IDX_STATUS_D});
    send_request(FUNC_WRITE, PORT_DATA, 8'h5A);
    // top RAM byte
    send_request(FUNC_WRITE, PORT_INDEX, 8'h7F);
    send_request(FUNC_WRITE, PORT_DATA, 8'hA5);
    send_request(FUNC_READ, PORT_DATA, 8'h00);
    // RAM write at a clock index is stored but the read still shows the clock
    send_request(FUNC_WRITE, PORT_INDEX, {1'b0, IDX_SECONDS});
    send_request(FUNC_WRITE, PORT_DATA, 8'h77);
    send_request(FUNC_READ, PORT_DATA, 8'h00);
    // index port read returns nothing
    send_request(FUNC_READ, PORT_INDEX, 8'h00);

    // Random phases: none idle (with a long receiver hold), sender idle,
    // receiver stalling, then both idling lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          rsp_stall_pct <= 0;
          hold_requests <= hold_requests + 1;  // sender keeps pushing meanwhile
        end
        1: begin
          send_idle_pct = 84;
          rsp_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct <= 84;
          // sender pause until the block has drained
          req_valid <= 1'b0;
          do @(posedge clk); while (sb.outstanding() != 0);
        end
        default: begin
          send_idle_pct = 16;
          rsp_stall_pct <= 16;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_burst();
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (8) @(posedge clk);   // room for any stray response

    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d read results never returned", sb.outstanding()));
    if (sb.mismatches == 0)
      $display("cmos_rtc_register_port_core test passed");
    else
      $display("cmos_rtc_register_port_core test failed");
    $finish;
  end

endmodule
